// File: src/suset_pkg.sv
// shared types and constants for the sorted unique set table
`timescale 1ns / 1ps

package suset_pkg;

	localparam int CAPACITY = 16;
	localparam int VALUE_W  = 32;
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	typedef logic signed [VALUE_W-1:0] value_t;
	typedef logic [CNT_W-1:0] count_t;

	typedef enum logic [1:0] {
		FUNC_INSERT = 2'd0,
		FUNC_DELETE = 2'd1,
		FUNC_LOOKUP = 2'd2
	} func_t;

	typedef enum logic [1:0] {
		ST_DONE      = 2'd0,
		ST_DUPLICATE = 2'd1,
		ST_ABSENT    = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

	// shift commands broadcast to every cell
	typedef struct packed {
		logic ins;
		logic del;
	} ctrl_t;

endpackage

// File: src/sorted_unique_set_table_unit.sv
// top level of the sorted unique set table: operand stage, cell row and result register
`timescale 1ns / 1ps

// Sorted set of distinct signed values kept in ascending order in a row of cells.
// Input channel: in_valid / in_stall with func (insert, delete, lookup) and
// item_value. Output channel: out_valid / out_stall with status, present and
// member_count; every input transaction gives exactly one output transaction.
// A transaction is registered in an operand stage; in the next cycle every cell
// compares its entry with the key at once, the hits are combined, and on insert
// or delete each cell takes the key or its neighbour's entry in the same edge
// while the result is written to the output register.
// out_valid rises when the operand stage executes into the output register.
// Throughput: one transaction per cycle unless the receiver stalls; the operand
// stage moves on whenever the output register is empty or being taken, so the next
// item sees the updated row. When the receiver stalls the result holds, the
// operand stage fills, and then in_stall rises until out_stall falls.
// Reset (arst_n low) empties the set (count zero) and drops both stages; cell
// contents are not cleared, cells at or above the count are never looked at.
module sorted_unique_set_table_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         func,
	input  logic signed [31:0] item_value,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         status,
	output logic               present,
	output logic [4:0]         member_count
);

	localparam int N = suset_pkg::CAPACITY;

	// operand stage
	logic              op_valid_s1;
	logic [1:0]        func_s1;
	suset_pkg::value_t key_s1;

	// set state and result register
	suset_pkg::count_t count_q;
	logic              out_valid_q;
	suset_pkg::status_t status_q;
	logic              present_q;
	suset_pkg::count_t count_out_q;

	// cell row
	suset_pkg::value_t entry_v [N];
	logic [N-1:0]      lt_v;
	logic [N-1:0]      eq_v;
	logic [N-1:0]      occ_v;
	suset_pkg::ctrl_t  ctrl;

	logic              exec;
	logic              found;
	logic              full;
	suset_pkg::status_t status_d;
	logic              present_d;
	suset_pkg::count_t count_d;

	// the operand stage executes when the result register can take its answer
	assign exec     = op_valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = op_valid_s1 && !exec;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			op_valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			func_s1 <= func;
			key_s1  <= item_value;
		end
	end

	// cells at or above the count hold stale data and never hit
	genvar gi;
	generate
		for (gi = 0; gi < N; gi++) begin : g_cell
			assign occ_v[gi] = count_q > suset_pkg::CNT_W'(gi);

			suset_cell u_cell (
				.clk        (clk),
				.ctrl       (ctrl),
				.key        (key_s1),
				.occupied   (occ_v[gi]),
				.prev_lt    ((gi == 0) ? 1'b1 : lt_v[(gi == 0) ? 0 : gi-1]),
				.prev_entry (entry_v[(gi == 0) ? 0 : gi-1]),
				.next_entry (entry_v[(gi == N-1) ? N-1 : gi+1]),
				.lt         (lt_v[gi]),
				.eq         (eq_v[gi]),
				.entry      (entry_v[gi])
			);
		end
	endgenerate

	assign found = |eq_v;
	assign full  = count_q == suset_pkg::CNT_W'(N);

	// decide the outcome of the staged transaction
	always_comb begin
		status_d  = suset_pkg::ST_DONE;
		present_d = 1'b0;
		count_d   = count_q;
		ctrl      = '0;
		case (func_s1)
			suset_pkg::FUNC_INSERT: begin
				if (found) begin
					status_d = suset_pkg::ST_DUPLICATE;
				end else if (full) begin
					status_d = suset_pkg::ST_FULL;
				end else begin
					ctrl.ins = exec;
					count_d  = count_q + suset_pkg::CNT_W'(1);
				end
			end
			suset_pkg::FUNC_DELETE: begin
				if (found) begin
					ctrl.del  = exec;
					present_d = 1'b1;
					count_d   = count_q - suset_pkg::CNT_W'(1);
				end else begin
					status_d = suset_pkg::ST_ABSENT;
				end
			end
			suset_pkg::FUNC_LOOKUP: begin
				if (found) begin
					present_d = 1'b1;
				end else begin
					status_d = suset_pkg::ST_ABSENT;
				end
			end
			default: begin
				// unused code: no change, plain done result
				status_d = suset_pkg::ST_DONE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (exec) begin
				count_q     <= count_d;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (exec) begin
			status_q    <= status_d;
			present_q   <= present_d;
			count_out_q <= count_d;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign present      = present_q;
	assign member_count = count_out_q;

endmodule

// File: src/suset_cell.sv
// one table cell: holds an entry, compares it with the key, shifts with its neighbours
`timescale 1ns / 1ps

module suset_cell (
	input  logic             clk,
	input  suset_pkg::ctrl_t ctrl,
	input  suset_pkg::value_t key,
	input  logic             occupied,
	input  logic             prev_lt,
	input  suset_pkg::value_t prev_entry,
	input  suset_pkg::value_t next_entry,
	output logic             lt,
	output logic             eq,
	output suset_pkg::value_t entry
);

	suset_pkg::value_t entry_q;

	assign entry = entry_q;
	assign lt    = occupied && (entry_q < key);
	assign eq    = occupied && (entry_q == key);

	always_ff @(posedge clk) begin
		if (ctrl.ins && !lt) begin
			// first cell not below the key takes the key, the rest move up
			entry_q <= prev_lt ? key : prev_entry;
		end else if (ctrl.del && !lt) begin
			entry_q <= next_entry;
		end
	end

endmodule

// File: test/suset_checker.sv
// checker for the sorted unique set table: predicts every result and compares it
`timescale 1ns / 1ps

module suset_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_stall,
	input  logic [1:0]        func,
	input  suset_pkg::value_t item_value,
	input  logic              out_valid,
	input  logic              out_stall,
	input  logic [1:0]        status,
	input  logic              present,
	input  logic [4:0]        member_count,
	output int                mismatches,
	output int                outstanding
);

	typedef struct {
		suset_pkg::status_t st;
		logic               pres;
		suset_pkg::count_t  cnt;
	} set_outcome_t;

	// own copy of the table, ascending and distinct below set_size
	suset_pkg::value_t set_row [suset_pkg::CAPACITY];
	suset_pkg::count_t set_size;
	set_outcome_t      awaited_outcomes [$];

	function automatic set_outcome_t apply_set_op(input logic [1:0] op,
		input suset_pkg::value_t v);
		set_outcome_t r;
		int           pos;
		int           i;
		bit           hit;
		r.st   = suset_pkg::ST_DONE;
		r.pres = 1'b0;
		pos    = 0;
		while (pos < set_size && set_row[pos] < v)
			pos++;
		hit = (pos < set_size) && (set_row[pos] == v);
		case (op)
			suset_pkg::FUNC_INSERT: begin
				if (hit)
					r.st = suset_pkg::ST_DUPLICATE;
				else if (set_size == suset_pkg::CAPACITY)
					r.st = suset_pkg::ST_FULL;
				else begin
					for (i = set_size; i > pos; i--)
						set_row[i] = set_row[i-1];
					set_row[pos] = v;
					set_size++;
				end
			end
			suset_pkg::FUNC_DELETE: begin
				if (hit) begin
					for (i = pos; i + 1 < set_size; i++)
						set_row[i] = set_row[i+1];
					set_size--;
					r.pres = 1'b1;
				end else
					r.st = suset_pkg::ST_ABSENT;
			end
			suset_pkg::FUNC_LOOKUP: begin
				if (hit)
					r.pres = 1'b1;
				else
					r.st = suset_pkg::ST_ABSENT;
			end
			default: ;
		endcase
		r.cnt = set_size;
		return r;
	endfunction

	task automatic report_mismatch(input string what);
		mismatches++;
		$display("[%0t] mismatch: %s", $time, what);
	endtask

	always @(posedge clk or negedge arst_n) begin
		set_outcome_t exp_o;
		if (!arst_n) begin
			awaited_outcomes.delete();
			set_size    = '0;
			mismatches  = 0;
			outstanding <= 0;
		end else begin
			if ($isunknown(out_valid))
				report_mismatch("out_valid unknown");
			// results first: a transaction accepted now cannot already have its result
			if (out_valid && !out_stall) begin
				if (awaited_outcomes.size() == 0)
					report_mismatch("result with no transaction pending");
				else begin
					exp_o = awaited_outcomes.pop_front();
					if (status !== exp_o.st)
						report_mismatch($sformatf("status %0d, expected %0d",
							status, exp_o.st));
					if (present !== exp_o.pres)
						report_mismatch($sformatf("present %0b, expected %0b",
							present, exp_o.pres));
					if (member_count !== exp_o.cnt)
						report_mismatch($sformatf("member_count %0d, expected %0d",
							member_count, exp_o.cnt));
				end
			end
			if (in_valid && !in_stall)
				awaited_outcomes.push_back(apply_set_op(func, item_value));
			outstanding <= awaited_outcomes.size();
		end
	end

endmodule

// File: test/tb.sv
// top of the sorted unique set table testbench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module tb;

	// the block ignores the fourth operation code, it is still driven
	localparam logic [1:0]        FUNC_UNUSED = 2'd3;
	localparam suset_pkg::value_t VAL_MIN     = 32'h8000_0000;
	localparam suset_pkg::value_t VAL_MAX     = 32'h7fff_ffff;
	localparam int                POOL_N      = 24;
	// slowest correct run is well under this limit, so it is generous
	localparam int                CYCLE_LIMIT = 200_000;

	logic              clk          = 1'b0;
	logic              arst_n;
	logic              in_valid     = 1'b0;
	logic              in_stall;
	logic [1:0]        func         = suset_pkg::FUNC_INSERT;
	suset_pkg::value_t item_value   = '0;
	logic              out_valid;
	logic              out_stall    = 1'b0;
	logic [1:0]        status;
	logic              present;
	logic [4:0]        member_count;

	int                mismatches;
	int                outstanding;
	int unsigned       cycle_cnt    = 0;

	// idling knobs, percent per cycle
	int                send_idle_pct = 0;
	int                stall_pct     = 0;

	// random operand pool; small so that duplicates, hits and a full table happen
	suset_pkg::value_t value_pool [POOL_N];
	bit                filling       = 1'b0;
	int                mode_left     = 0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	sorted_unique_set_table_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.func         (func),
		.item_value   (item_value),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.present      (present),
		.member_count (member_count)
	);

	suset_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.func         (func),
		.item_value   (item_value),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.present      (present),
		.member_count (member_count),
		.mismatches   (mismatches),
		.outstanding  (outstanding)
	);

	// receiver back-pressure, redrawn every cycle
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	// watchdog against a hung handshake or a lost result
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// offer one transaction, hold it until taken, then maybe go idle a while
	task automatic send_item(input logic [1:0] op, input suset_pkg::value_t v);
		in_valid   <= 1'b1;
		func       <= op;
		item_value <= v;
		do
			@(posedge clk);
		while (in_stall);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	// hold off the sender until every result has come back
	task automatic wait_drained();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (outstanding != 0);
	endtask

	// extremes always in the pool, the rest a mix of wide and small values
	task automatic refresh_pool();
		int i;
		value_pool[0] = VAL_MIN;
		value_pool[1] = VAL_MAX;
		value_pool[2] = '0;
		value_pool[3] = -1;
		for (i = 4; i < POOL_N; i++) begin
			if (i % 2)
				value_pool[i] = $urandom;
			else
				value_pool[i] = $signed($urandom_range(64)) - 32;
		end
	endtask

	function automatic suset_pkg::value_t pick_value();
		if ($urandom_range(9) == 0)
			return $urandom;
		return value_pool[$urandom_range(POOL_N - 1)];
	endfunction

	// alternate stretches that fill the table and stretches that drain it
	function automatic logic [1:0] pick_op();
		int r;
		if (mode_left == 0) begin
			filling   = !filling;
			mode_left = $urandom_range(15, 50);
		end
		mode_left--;
		r = $urandom_range(99);
		if (r < 3)
			return FUNC_UNUSED;
		if (r < (filling ? 65 : 25))
			return suset_pkg::FUNC_INSERT;
		if (r < 80)
			return suset_pkg::FUNC_DELETE;
		return suset_pkg::FUNC_LOOKUP;
	endfunction

	initial begin
		int ph;
		int n;
		int k;
		// asserted in the nba region so the async reset edge is never missed
		arst_n <= 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty set, unused code
		send_item(suset_pkg::FUNC_LOOKUP, 0);
		send_item(suset_pkg::FUNC_DELETE, 5);
		send_item(FUNC_UNUSED, 7);
		// extremes and neighbours of zero
		send_item(suset_pkg::FUNC_INSERT, VAL_MIN);
		send_item(suset_pkg::FUNC_INSERT, 0);
		send_item(suset_pkg::FUNC_INSERT, -1);
		send_item(suset_pkg::FUNC_INSERT, 1);
		// delete of a value above every stored entry
		send_item(suset_pkg::FUNC_DELETE, 100);
		send_item(suset_pkg::FUNC_INSERT, VAL_MAX);
		// duplicate, then a hit at the very bottom
		send_item(suset_pkg::FUNC_INSERT, 0);
		send_item(suset_pkg::FUNC_LOOKUP, VAL_MIN);
		// fill to capacity
		for (k = 2; k <= 12; k++)
			send_item(suset_pkg::FUNC_INSERT, k * k * 1000);
		// full table, and a duplicate while full
		send_item(suset_pkg::FUNC_INSERT, 3);
		send_item(suset_pkg::FUNC_INSERT, VAL_MAX);
		// remove both ends and a middle entry, then miss the same one
		send_item(suset_pkg::FUNC_DELETE, VAL_MIN);
		send_item(suset_pkg::FUNC_DELETE, VAL_MAX);
		send_item(suset_pkg::FUNC_DELETE, 0);
		send_item(suset_pkg::FUNC_DELETE, 0);
		wait_drained();

		// random phases: free running, sender idling, receiver stalling, both
		for (ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 79; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 79; end
				default: begin send_idle_pct = 22; stall_pct = 22; end
			endcase
			refresh_pool();
			for (n = 0; n < 170; n++)
				send_item(pick_op(), pick_value());
			wait_drained();
		end

		// let any straggling result show up before the verdict
		stall_pct = 0;
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
